>>> rtl/core/asdt_pkg.sv
// Shared types and constants of the analog scan deadband tracker.
// Holds the word kinds, configuration register indexes and the pin map.
// No dependencies.
package asdt_pkg;

  // pins behind one converter module (8 channels x 8 mux steps)
  localparam int unsigned PINS_PER_MODULE = 64;
  localparam int unsigned PIN_W           = 6;
  localparam int unsigned VALUE_W         = 12;
  localparam int unsigned TICK_W          = 16;

  // link led pwm sweep: 20-tick period, 100 sweep steps, 4000-tick triangle
  localparam logic [4:0]  PwmPeriodLast = 5'd19;
  localparam logic [6:0]  PwmSweepLast  = 7'd99;
  localparam logic [11:0] PwmTriLast    = 12'd3999;
  localparam logic [11:0] PwmTriHalf    = 12'd2000;
  localparam logic [4:0]  PwmPeriod     = 5'd20;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_SCAN_START = 2'd0,
    KIND_CONVERSION = 2'd1,
    KIND_SCAN_END   = 2'd2,
    KIND_READ       = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODULES_IN_USE = 3'd0,
    CFG_MODULE_ENABLE  = 3'd1,
    CFG_PINS_USED_M0   = 3'd2,
    CFG_PINS_USED_M1   = 3'd3,
    CFG_DEADBAND_M0    = 3'd4,
    CFG_DEADBAND_M1    = 3'd5
  } cfg_idx_e;

  // mux step to low pin bits
  function automatic logic [2:0] mux_to_pin(input logic [2:0] step);
    logic [2:0] pin;
    case (step)
      3'd0:    pin = 3'd6;
      3'd1:    pin = 3'd3;
      3'd2:    pin = 3'd4;
      3'd3:    pin = 3'd2;
      3'd4:    pin = 3'd5;
      3'd5:    pin = 3'd0;
      3'd6:    pin = 3'd7;
      default: pin = 3'd1;
    endcase
    return pin;
  endfunction

  // pwm output bit from the decomposed tick counter
  // step / 5 by reciprocal: exact for step below 1024
  function automatic logic pwm_bit(input logic [4:0]  phase,
                                   input logic [6:0]  step,
                                   input logic [11:0] tri_pos);
    logic [14:0] prod;
    logic [4:0]  duty;
    prod = 15'(step) * 15'd205;
    duty = prod[14:10];
    if (tri_pos > PwmTriHalf) begin
      duty = PwmPeriod - duty;
    end
    return phase > duty;
  endfunction

endpackage

>>> rtl/core/analog_scan_deadband_tracker_top.sv
// Top level of the analog scan deadband tracker.
// Uses asdt_pkg and one asdt_ram instance for the stored pin values.
//
// Usage: words arrive on the s_axis channel; tuser carries the kind (scan
// start, conversion, scan end, read). Every accepted word yields exactly one
// result word on m_axis. A conversion word is mapped to a pin through the
// current mux step and channel, compared against the stored value and the
// module deadband, and stored/flagged as needed; the result also carries the
// shift-register byte with the mux select and the link led bit.
// The store read is issued at acceptance into the compare stage registers;
// the compare and write-back run in the compare stage, which loads the
// output register when it fires. One word is taken every cycle while the
// output is not stalled; a write to a pin read by the following word is
// forwarded, so back-to-back conversions to the same pin see the new value.
// Reset clears the mux step, tick counter, link bit and first-scan flag and
// marks every stored value as zero through per-entry valid bits, so words are
// taken right after reset. When m_axis_tready is low the result holds, one
// more word may sit in the compare stage, and s_axis_tready then drops. The
// user writes one config register per cycle while the block idles (not enforced).
module analog_scan_deadband_tracker_top
  import asdt_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // module_req[0], channel[3:1], rx_high[11:4], rx_low[19:12], read_pin[25:20]
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // module_out[0], pin_out[6:1], value_out[18:7], previous_value[30:19],
  // shift_byte[38:31], link_led[39]
  output logic [39:0] m_axis_tdata,
  // changed[0]
  output logic        m_axis_tuser
);

  localparam int unsigned Depth = MODULE_COUNT * PINS_PER_MODULE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [1:0]  NumModW = 2'(MODULE_COUNT);

  // configuration registers
  logic [1:0] modules_in_use_q;
  logic [1:0] module_enable_q;
  logic [6:0] pins_used_q [2];
  logic [7:0] deadband_q [2];

  // scan control state
  logic [2:0]        mux_step_q, mux_step_d;
  logic              first_scan_q, first_scan_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [4:0]        phase_q, phase_d;
  logic [6:0]        sweep_q, sweep_d;
  logic [11:0]       tri_q, tri_d;
  logic              link_q, link_d;

  // input field unpacking
  kind_e              in_kind;
  logic               in_mod;
  logic [2:0]         in_chan;
  logic [7:0]         in_rx_high;
  logic [7:0]         in_rx_low;
  logic [PIN_W-1:0]   in_rpin;
  logic [PIN_W-1:0]   in_pin;
  logic [VALUE_W-1:0] in_value;
  logic [2:0]         in_sel;
  logic [AddrW-1:0]   in_addr;
  logic               in_accept;

  // compare stage
  logic               s1_valid_q;
  kind_e              s1_kind_q;
  logic               s1_mod_q;
  logic [PIN_W-1:0]   s1_pin_q;
  logic [VALUE_W-1:0] s1_value_q;
  logic [2:0]         s1_sel_q;
  logic               s1_link_q;
  logic               s1_first_q;
  logic               s1_fire;
  logic [AddrW-1:0]   s1_addr;
  logic               s1_valid_mod;
  logic               s1_scanned;
  logic [VALUE_W-1:0] s1_stored;
  logic [VALUE_W-1:0] s1_diff;
  logic               s1_update;
  logic               s1_changed;
  logic               s1_fwd_hit;

  // store, valid bits and write forwarding
  logic [Depth-1:0]   entry_valid_q;
  logic               ram_we;
  logic [VALUE_W-1:0] ram_rdata;
  logic               wr_valid_q;
  logic [AddrW-1:0]   wr_addr_q;
  logic [VALUE_W-1:0] wr_data_q;

  // output register
  logic        out_valid_q;
  logic [39:0] out_data_q, out_data_d;
  logic        out_changed_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modules_in_use_q <= 2'd2;
      module_enable_q  <= 2'd3;
      pins_used_q[0]   <= 7'd64;
      pins_used_q[1]   <= 7'd64;
      deadband_q[0]    <= 8'd31;
      deadband_q[1]    <= 8'd31;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULES_IN_USE: modules_in_use_q <= cfg_data_i[1:0];
        CFG_MODULE_ENABLE:  module_enable_q  <= cfg_data_i[1:0];
        CFG_PINS_USED_M0:   pins_used_q[0]   <= cfg_data_i[6:0];
        CFG_PINS_USED_M1:   pins_used_q[1]   <= cfg_data_i[6:0];
        CFG_DEADBAND_M0:    deadband_q[0]    <= cfg_data_i;
        CFG_DEADBAND_M1:    deadband_q[1]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshakes
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // unpack and map the incoming word
  always_comb begin
    in_kind    = kind_e'(s_axis_tuser);
    in_mod     = s_axis_tdata[0];
    in_chan    = s_axis_tdata[3:1];
    in_rx_high = s_axis_tdata[11:4];
    in_rx_low  = s_axis_tdata[19:12];
    in_rpin    = s_axis_tdata[25:20];
    in_value   = {in_rx_high[3:0], in_rx_low};
    in_pin     = (in_kind == KIND_READ) ? in_rpin : {~in_chan, mux_to_pin(mux_step_q)};
    in_addr    = AddrW'({in_mod, in_pin});
  end

  // scan control next state, including the decomposed pwm counters
  always_comb begin
    mux_step_d   = mux_step_q;
    first_scan_d = first_scan_q;
    tick_d       = tick_q;
    phase_d      = phase_q;
    sweep_d      = sweep_q;
    tri_d        = tri_q;
    link_d       = link_q;
    in_sel       = mux_step_q;
    case (in_kind)
      KIND_SCAN_START: begin
        tick_d = tick_q + TICK_W'(1);
        if (tick_q == {TICK_W{1'b1}}) begin
          phase_d = '0;
          sweep_d = '0;
          tri_d   = '0;
        end else begin
          phase_d = (phase_q == PwmPeriodLast) ? 5'd0 : phase_q + 5'd1;
          if (phase_q == PwmPeriodLast) begin
            sweep_d = (sweep_q == PwmSweepLast) ? 7'd0 : sweep_q + 7'd1;
          end
          tri_d = (tri_q == PwmTriLast) ? 12'd0 : tri_q + 12'd1;
        end
        link_d = pwm_bit(phase_d, sweep_d, tri_d);
      end
      KIND_CONVERSION: begin
        if (in_chan == 3'd7) begin
          in_sel = mux_step_q + 3'd1;
        end
      end
      KIND_SCAN_END: begin
        mux_step_d = mux_step_q + 3'd1;
        in_sel     = mux_step_d;
        if (mux_step_d == 3'd0) begin
          first_scan_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // scan control registers, updated on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_step_q   <= '0;
      first_scan_q <= 1'b0;
      tick_q       <= '0;
      phase_q      <= '0;
      sweep_q      <= '0;
      tri_q        <= '0;
      link_q       <= 1'b0;
    end else if (in_accept) begin
      mux_step_q   <= mux_step_d;
      first_scan_q <= first_scan_d;
      tick_q       <= tick_d;
      phase_q      <= phase_d;
      sweep_q      <= sweep_d;
      tri_q        <= tri_d;
      link_q       <= link_d;
    end
  end

  // compare stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // compare stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q  <= in_kind;
      s1_mod_q   <= in_mod;
      s1_pin_q   <= in_pin;
      s1_value_q <= in_value;
      s1_sel_q   <= in_sel;
      s1_link_q  <= link_d;
      s1_first_q <= first_scan_q;
    end
  end

  // stored value store
  asdt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(Depth)
  ) u_values (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(s1_addr),
    .wdata_i(s1_value_q),
    .re_i   (in_accept),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  // stored value lookup with forwarding and deadband check
  always_comb begin
    s1_addr      = AddrW'({s1_mod_q, s1_pin_q});
    s1_valid_mod = {1'b0, s1_mod_q} < NumModW;
    s1_scanned   = s1_valid_mod && ({1'b0, s1_mod_q} < modules_in_use_q) &&
                   module_enable_q[s1_mod_q];
    s1_fwd_hit   = wr_valid_q && (wr_addr_q == s1_addr);
    if (!s1_valid_mod) begin
      s1_stored = '0;
    end else if (s1_fwd_hit) begin
      s1_stored = wr_data_q;
    end else if (entry_valid_q[s1_addr]) begin
      s1_stored = ram_rdata;
    end else begin
      s1_stored = '0;
    end
    s1_diff    = (s1_value_q > s1_stored) ? s1_value_q - s1_stored
                                          : s1_stored - s1_value_q;
    s1_update  = (s1_kind_q == KIND_CONVERSION) && s1_scanned &&
                 (!s1_first_q || (s1_diff > {4'd0, deadband_q[s1_mod_q]}));
    s1_changed = s1_update && s1_first_q &&
                 ({1'b0, s1_pin_q} < pins_used_q[s1_mod_q]);
    ram_we     = s1_fire && s1_update;
  end

  // valid bits and last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      wr_valid_q    <= 1'b0;
    end else begin
      if (ram_we) begin
        entry_valid_q[s1_addr] <= 1'b1;
      end
      if (s1_fire) begin
        wr_valid_q <= ram_we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      wr_addr_q <= s1_addr;
      wr_data_q <= s1_value_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word assembly
  always_comb begin
    out_data_d        = '0;
    out_data_d[38:31] = {s1_sel_q, 4'd0, s1_link_q};
    out_data_d[39]    = s1_link_q;
    case (s1_kind_q)
      KIND_CONVERSION: begin
        out_data_d[0]     = s1_mod_q;
        out_data_d[6:1]   = s1_pin_q;
        out_data_d[18:7]  = s1_value_q;
        out_data_d[30:19] = s1_stored;
      end
      KIND_READ: begin
        out_data_d[0]    = s1_mod_q;
        out_data_d[6:1]  = s1_pin_q;
        out_data_d[18:7] = s1_stored;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_changed_q <= s1_changed;
      out_data_q    <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_changed_q;

endmodule

>>> rtl/core/asdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the stored pin values. No dependencies.
module asdt_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the analog scan deadband tracker top level.
// Depends on asdt_pkg and analog_scan_deadband_tracker_top; a scoreboard class
// predicts every result word and checks the m_axis stream against it.
module testbench;
  import asdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ModuleCount = 2;
  // index past the last register, must be ignored by the block
  localparam logic [2:0] CfgIdxUnused = 3'd7;
  // mux step to low pin bits
  localparam logic [2:0] MuxPin [8] = '{3'd6, 3'd3, 3'd4, 3'd2, 3'd5, 3'd0, 3'd7, 3'd1};

  typedef struct packed {
    kind_e      kind;
    logic       mod;
    logic [2:0] chn;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [5:0] rpin;
  } word_t;

  typedef struct packed {
    logic        changed;
    logic        module_out;
    logic [5:0]  pin_out;
    logic [11:0] value_out;
    logic [11:0] previous_value;
    logic [7:0]  shift_byte;
    logic        link_led;
  } result_t;

  // predicts the tracker and holds the result words still due
  class scan_scoreboard;
    logic [1:0]  mods_in_use;
    logic [1:0]  en_mask;
    logic [6:0]  pins_used [2];
    logic [7:0]  deadband [2];
    logic [11:0] pin_store [2][64];
    logic [2:0]  mux;
    logic        first_done;
    logic [15:0] tick;
    logic        link;
    result_t     due_q [$];
    int unsigned errors;

    function new();
      mods_in_use  = 2'd2;
      en_mask      = 2'd3;
      pins_used[0] = 7'd64;
      pins_used[1] = 7'd64;
      deadband[0]  = 8'd31;
      deadband[1]  = 8'd31;
      foreach (pin_store[m, p]) pin_store[m][p] = '0;
      mux        = '0;
      first_done = 1'b0;
      tick       = '0;
      link       = 1'b0;
      errors     = 0;
    endfunction

    // triangular sweep of the link led duty cycle
    function logic sweep_bit(int unsigned ctr);
      int unsigned duty;
      duty = ((ctr / 20) % 100) / 5;
      if ((ctr % 4000) > 2000) begin
        duty = 20 - duty;
      end
      return (ctr % 20) > duty;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        CFG_MODULES_IN_USE: mods_in_use  = data[1:0];
        CFG_MODULE_ENABLE:  en_mask      = data[1:0];
        CFG_PINS_USED_M0:   pins_used[0] = data[6:0];
        CFG_PINS_USED_M1:   pins_used[1] = data[6:0];
        CFG_DEADBAND_M0:    deadband[0]  = data;
        CFG_DEADBAND_M1:    deadband[1]  = data;
        default: ;
      endcase
    endfunction

    function int unsigned pin_of(logic [2:0] chn);
      return MuxPin[mux] + 8 * (7 - chn);
    endfunction

    function int unsigned stored_value(logic mod, logic [2:0] chn);
      return pin_store[mod][pin_of(chn)];
    endfunction

    // apply one accepted word to the model and queue its result
    function void note_word(word_t w);
      result_t     r;
      int unsigned pin;
      int unsigned val;
      int unsigned prev;
      int unsigned diff;
      logic [2:0]  sel;
      r   = '0;
      sel = mux;
      case (w.kind)
        KIND_SCAN_START: begin
          tick = tick + 16'd1;
          link = sweep_bit(tick);
        end
        KIND_CONVERSION: begin
          pin  = pin_of(w.chn);
          val  = {w.hi[3:0], w.lo};
          prev = pin_store[w.mod][pin];
          if (w.mod < mods_in_use && en_mask[w.mod]) begin
            diff = (val > prev) ? val - prev : prev - val;
            if (!first_done || diff > deadband[w.mod]) begin
              pin_store[w.mod][pin] = 12'(val);
              if (first_done && pin < pins_used[w.mod]) r.changed = 1'b1;
            end
          end
          r.module_out     = w.mod;
          r.pin_out        = 6'(pin);
          r.value_out      = 12'(val);
          r.previous_value = 12'(prev);
          if (w.chn == 3'd7) sel = mux + 3'd1;
        end
        KIND_SCAN_END: begin
          mux = mux + 3'd1;
          if (mux == 3'd0) first_done = 1'b1;
          sel = mux;
        end
        default: begin
          r.module_out = w.mod;
          r.pin_out    = w.rpin;
          r.value_out  = pin_store[w.mod][w.rpin];
        end
      endcase
      r.shift_byte = {sel, 4'b0000, link};
      r.link_led   = link;
      due_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = due_q.pop_front();
      cmp("changed", want.changed, got.changed);
      cmp("module_out", want.module_out, got.module_out);
      cmp("pin_out", want.pin_out, got.pin_out);
      cmp("value_out", want.value_out, got.value_out);
      cmp("previous_value", want.previous_value, got.previous_value);
      cmp("shift_byte", want.shift_byte, got.shift_byte);
      cmp("link_led", want.link_led, got.link_led);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  scan_scoreboard sb = new();
  int unsigned    src_idle_pct  = 0;
  int unsigned    snk_stall_pct = 0;
  int unsigned    words_sent    = 0;

  analog_scan_deadband_tracker_top #(
    .MODULE_COUNT(ModuleCount)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result('{changed:        m_axis_tuser,
                        module_out:     m_axis_tdata[0],
                        pin_out:        m_axis_tdata[6:1],
                        value_out:      m_axis_tdata[18:7],
                        previous_value: m_axis_tdata[30:19],
                        shift_byte:     m_axis_tdata[38:31],
                        link_led:       m_axis_tdata[39]});
    end
  end

  // offer one word, wait for acceptance, then maybe idle for a while
  task automatic send_word(input word_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.kind;
    s_axis_tdata  <= {6'b0, w.rpin, w.lo, w.hi, w.chn, w.mod};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(w);
    words_sent++;
    @(negedge clk_i);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic send_fields(input kind_e kind, input logic mod, input logic [2:0] chn,
                             input logic [7:0] hi, input logic [7:0] lo,
                             input logic [5:0] rpin);
    send_word('{kind: kind, mod: mod, chn: chn, hi: hi, lo: lo, rpin: rpin});
  endtask

  // random word of the given kind, unused fields random too
  function automatic word_t rand_word(input kind_e kind);
    word_t w;
    w      = word_t'({$urandom, $urandom});
    w.kind = kind;
    return w;
  endfunction

  // conversion near the stored value half of the time, to probe the deadband
  function automatic word_t conv_word(input logic mod, input logic [2:0] chn);
    word_t w;
    int    v;
    int    delta;
    w     = rand_word(KIND_CONVERSION);
    w.mod = mod;
    w.chn = chn;
    if ($urandom_range(1)) begin
      delta = $urandom_range(sb.deadband[mod] + 4);
      v = sb.stored_value(mod, chn);
      v = $urandom_range(1) ? v + delta : v - delta;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      w.hi[3:0] = v[11:8];
      w.lo      = v[7:0];
    end
    return w;
  endfunction

  task automatic hold_input();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // all six registers, junk in the unused upper bits of the narrow ones
  task automatic apply_settings(input logic [1:0] mu, input logic [1:0] en,
                                input logic [6:0] p0, input logic [6:0] p1,
                                input logic [7:0] d0, input logic [7:0] d1);
    write_reg(CFG_MODULES_IN_USE, {6'($urandom), mu});
    write_reg(CFG_MODULE_ENABLE, {6'($urandom), en});
    write_reg(CFG_PINS_USED_M0, {1'($urandom), p0});
    write_reg(CFG_PINS_USED_M1, {1'($urandom), p1});
    write_reg(CFG_DEADBAND_M0, d0);
    write_reg(CFG_DEADBAND_M1, d1);
    cfg_we_i <= 1'b0;
  endtask

  // one well-formed scan with random content, some noise and dropped words
  task automatic run_scan();
    send_word(rand_word(KIND_SCAN_START));
    for (int c = 0; c < 8; c++) begin
      for (int m = 0; m < ModuleCount; m++) begin
        if ($urandom_range(9) != 0) send_word(conv_word(1'(m), 3'(c)));
        if ($urandom_range(7) == 0) send_word(rand_word(KIND_READ));
        if ($urandom_range(19) == 0) send_word(rand_word(kind_e'($urandom_range(3))));
      end
    end
    send_word(rand_word(KIND_SCAN_END));
  endtask

  initial begin
    int unsigned target;
    int unsigned midpoint;
    bit          paused;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first scan, mux wrap, deadband edge, reads
    send_fields(KIND_SCAN_START, 1'b0, 3'd0, 8'h00, 8'h00, 6'd0);
    send_fields(KIND_CONVERSION, 1'b0, 3'd7, 8'hff, 8'hff, 6'd63);
    send_fields(KIND_CONVERSION, 1'b1, 3'd0, 8'h00, 8'h00, 6'd0);
    send_fields(KIND_CONVERSION, 1'b0, 3'd3, 8'h5a, 8'ha5, 6'd21);
    send_fields(KIND_READ, 1'b0, 3'd0, 8'h00, 8'h00, 6'd6);
    send_fields(KIND_READ, 1'b1, 3'd7, 8'hff, 8'hff, 6'd63);
    repeat (8) send_fields(KIND_SCAN_END, 1'b0, 3'd0, 8'h00, 8'h00, 6'd0);
    send_fields(KIND_CONVERSION, 1'b0, 3'd7, 8'h00, 8'h00, 6'd0);
    send_fields(KIND_CONVERSION, 1'b0, 3'd7, 8'h00, 8'h1f, 6'd0);
    send_fields(KIND_CONVERSION, 1'b0, 3'd7, 8'h00, 8'h20, 6'd0);
    send_fields(KIND_READ, 1'b0, 3'd0, 8'h00, 8'h00, 6'd6);
    send_fields(KIND_SCAN_START, 1'b1, 3'd7, 8'hff, 8'hff, 6'd63);
    send_fields(KIND_READ, 1'b0, 3'd0, 8'h00, 8'h00, 6'd0);

    // a stretch of the led sweep
    repeat (100) send_word(rand_word(KIND_SCAN_START));

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < 10; p++) begin
      hold_input();
      drain_results();
      case (p)
        0: begin
          write_reg(CfgIdxUnused, 8'($urandom));
          apply_settings(2'd2, 2'd3, 7'd64, 7'd64, 8'd31, 8'd31);
        end
        1: apply_settings(2'd3, 2'd3, 7'd0, 7'd127, 8'd0, 8'd255);
        2: apply_settings(2'd1, 2'd1, 7'd63, 7'd65, 8'd255, 8'd0);
        3: apply_settings(2'd0, 2'd0, 7'd64, 7'd1, 8'd8, 8'd8);
        4: apply_settings(2'd2, 2'd2, 7'd127, 7'd0, 8'd31, 8'd255);
        default: begin
          apply_settings(2'($urandom_range(1, 3)), 2'($urandom_range(1, 3)),
                         7'($urandom_range(127)), 7'($urandom_range(127)),
                         8'($urandom_range(63)), 8'($urandom_range(63)));
        end
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      target   = words_sent + 160;
      midpoint = words_sent + 80;
      paused   = 1'b0;
      while (words_sent < target) begin
        if (!paused && words_sent >= midpoint) begin
          // sender holds off until every result is back
          hold_input();
          drain_results();
          paused = 1'b1;
        end
        run_scan();
      end
    end

    // wind down
    hold_input();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    drain_results();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
